FILE: design/mmst_pkg.sv
`default_nettype none
package mmst_pkg;

   localparam int LEAVES_DEFAULT = 1024;

   // Matrix entry layout: e11 in the lowest 16 bits, then e12, e21, e22.
   localparam int ENT_W = 16;
   localparam int MAT_W = 4 * ENT_W;
   localparam logic [MAT_W-1:0] MAT_IDENT = 64'h0001_0000_0000_0001;

   localparam int MOD_W = 17;
   localparam int RECIP_W = 33;
   localparam logic [ENT_W-1:0] MODULUS_RESET = 16'hFFFF;

   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_MODULUS = 1'b0;

   localparam int FIFO_DEPTH = 4;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_RANGE,
      CMD_EMPTY,
      CMD_ROOT
   } cmd_kind_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic done;
      logic busy;
   } mul_stat_type;

   typedef struct packed {
      logic init_done;
   } back_stat_type;

   typedef struct packed {
      logic ready;
   } csr_stat_type;

   // Command word: {range_hi, range_lo, node, matrix, kind}.
   function automatic int cmd_width(input int leaves);
      cmd_width = 2 + MAT_W + 3 * ($clog2(leaves) + 1);
   endfunction

endpackage
`default_nettype wire

FILE: design/mmst_csr.sv
`default_nettype none
module mmst_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [mmst_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready,
   output logic [mmst_pkg::MOD_W-1:0]             mod_eff,
   output logic [mmst_pkg::RECIP_W-1:0]           recip,
   output mmst_pkg::csr_stat_type                 stat
);

   localparam int MW = mmst_pkg::MOD_W;
   localparam int RW = mmst_pkg::RECIP_W;
   localparam int CNT_W = $clog2(RW);

   logic [mmst_pkg::ENT_W-1:0] modulus_ff, modulus_in;
   logic                       busy_ff, busy_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [MW-1:0]              rem_ff, rem_in;
   logic [RW-1:0]              quo_ff, quo_in;
   logic                       wr_en;
   logic [MW:0]                trial;
   logic                       num_bit;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready
                  & (csr_paddr[2:2] == mmst_pkg::REG_MODULUS);
   assign csr_prdata = (csr_paddr[2:2] == mmst_pkg::REG_MODULUS) ?
                       {16'b0, modulus_ff} : 32'b0;

   // A stored zero stands for 2**16.
   assign mod_eff = (modulus_ff == '0) ? {1'b1, 16'b0} : {1'b0, modulus_ff};
   assign recip = quo_ff;
   assign stat.ready = ~busy_ff;

   // Restoring division of 2**32 by the modulus, one quotient bit a cycle.
   assign num_bit = (cnt_ff == CNT_W'(RW - 1));
   assign trial = {rem_ff, num_bit};

   always_comb begin
      modulus_in = modulus_ff;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (busy_ff) begin
         if (trial >= {1'b0, mod_eff}) begin
            rem_in = MW'(trial - {1'b0, mod_eff});
            quo_in = {quo_ff[RW-2:0], 1'b1};
         end else begin
            rem_in = trial[MW-1:0];
            quo_in = {quo_ff[RW-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
      if (wr_en) begin
         modulus_in = csr_pwdata[15:0];
         busy_in = 1'b1;
         cnt_in = CNT_W'(RW - 1);
         rem_in = '0;
         quo_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mmst_pkg::MODULUS_RESET;
         busy_ff <= 1'b1;
         cnt_ff <= CNT_W'(RW - 1);
         rem_ff <= '0;
         quo_ff <= '0;
      end else begin
         modulus_ff <= modulus_in;
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/mmst_front.sv
`default_nettype none
module mmst_front #(
   parameter int LEAVES = mmst_pkg::LEAVES_DEFAULT,
   localparam int LOG2P = $clog2(LEAVES),
   localparam int P = 1 << LOG2P,
   localparam int NW = LOG2P + 1,
   localparam int PW = LOG2P + 1,
   localparam int CW = mmst_pkg::cmd_width(LEAVES)
) (
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [95:0]          req_tdata,
   input  wire logic                 req_tuser,
   input  wire mmst_pkg::fifo_stat_type fifo_stat,
   input  wire mmst_pkg::back_stat_type back_stat,
   input  wire mmst_pkg::csr_stat_type  csr_stat,
   output logic                      push,
   output logic [CW-1:0]             push_data
);

   logic [9:0]                      leaf_index;
   logic [mmst_pkg::MAT_W-1:0]      leaf_mat;
   logic [31:0]                     left32, right32, rsat32, node32;
   logic                            load_ok, empty, root;
   mmst_pkg::cmd_kind_type          kind;

   assign req_tready = ~fifo_stat.full & back_stat.init_done & csr_stat.ready;

   assign leaf_index = req_tdata[9:0];
   assign leaf_mat = req_tdata[73:10];
   assign left32 = {22'b0, req_tdata[83:74]};
   assign right32 = {22'b0, req_tdata[93:84]};

   assign load_ok = {22'b0, leaf_index} < 32'(LEAVES);
   assign node32 = 32'(P) + {22'b0, leaf_index};
   assign rsat32 = (right32 > 32'(LEAVES - 1)) ? 32'(LEAVES - 1) : right32;
   assign empty = left32 > rsat32;
   // A span that is the whole tree comes back exactly as stored.
   assign root = (left32 == 32'b0) && (rsat32 == 32'(P - 1));

   always_comb begin
      if (req_tuser == 1'b0) begin
         kind = mmst_pkg::CMD_LOAD;
      end else if (empty) begin
         kind = mmst_pkg::CMD_EMPTY;
      end else if (root) begin
         kind = mmst_pkg::CMD_ROOT;
      end else begin
         kind = mmst_pkg::CMD_RANGE;
      end
   end

   // Loads beyond the leaf count are taken and dropped.
   assign push = req_tvalid & req_tready & (req_tuser | load_ok);
   assign push_data = {rsat32[PW-1:0], left32[PW-1:0], node32[NW-1:0], leaf_mat, kind};

endmodule
`default_nettype wire

FILE: design/mmst_fifo.sv
`default_nettype none
module mmst_fifo #(
   parameter int LEAVES = mmst_pkg::LEAVES_DEFAULT,
   localparam int CW = mmst_pkg::cmd_width(LEAVES)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire logic [CW-1:0]   push_data,
   input  wire logic            pop,
   output logic [CW-1:0]        head_data,
   output mmst_pkg::fifo_stat_type stat
);

   localparam int DEPTH = mmst_pkg::FIFO_DEPTH;
   localparam int AW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [CW-1:0]   entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;

   assign head_data = entry_ff[rd_ptr_ff];
   assign stat.full = (count_ff == CNTW'(DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/mmst_mul.sv
`default_nettype none
module mmst_mul (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [mmst_pkg::MAT_W-1:0]     mat_a,
   input  wire logic [mmst_pkg::MAT_W-1:0]     mat_b,
   input  wire logic [mmst_pkg::MOD_W-1:0]     mod_eff,
   input  wire logic [mmst_pkg::RECIP_W-1:0]   recip,
   output logic [mmst_pkg::MAT_W-1:0]          result,
   output mmst_pkg::mul_stat_type              stat
);

   localparam int EW = mmst_pkg::ENT_W;

   logic [31:0] pa [4];
   logic [31:0] pb [4];
   logic [32:0] s_ff [4], s_in [4];
   logic [32:0] s2_ff [4], s3_ff [4];
   logic [49:0] plo_ff [4], plo_in [4];
   logic [48:0] phi_ff [4], phi_in [4];
   logic [66:0] qsum [4];
   logic [32:0] q_ff [4], q_in [4];
   logic [49:0] diff [4];
   logic [18:0] r_ff [4], r_in [4];
   logic [EW-1:0] res_ff [4], res_in [4];
   logic [4:0]  vld_ff;
   logic [18:0] m1, m2, m3;

   assign m1 = 19'(mod_eff);
   assign m2 = m1 << 1;
   assign m3 = m1 + m2;

   // Entry i is row (i & 2) of a times column (i & 1) of b. The remainder uses
   // q = floor(s * floor(2**32 / m) / 2**32), which is low by at most two.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pa[i] = 32'(mat_a[EW*(i & 2) +: EW]) * 32'(mat_b[EW*(i & 1) +: EW]);
         pb[i] = 32'(mat_a[EW*((i & 2) + 1) +: EW]) * 32'(mat_b[EW*((i & 1) + 2) +: EW]);
         s_in[i] = {1'b0, pa[i]} + {1'b0, pb[i]};
         plo_in[i] = 50'(s_ff[i]) * 50'(recip[16:0]);
         phi_in[i] = 49'(s_ff[i]) * 49'(recip[32:17]);
         qsum[i] = 67'(plo_ff[i]) + {1'b0, phi_ff[i], 17'b0};
         q_in[i] = qsum[i][64:32];
         diff[i] = 50'(s3_ff[i]) - 50'(q_ff[i]) * 50'(mod_eff);
         r_in[i] = diff[i][18:0];
         if (r_ff[i] >= m3) begin
            res_in[i] = EW'(r_ff[i] - m3);
         end else if (r_ff[i] >= m2) begin
            res_in[i] = EW'(r_ff[i] - m2);
         end else if (r_ff[i] >= m1) begin
            res_in[i] = EW'(r_ff[i] - m1);
         end else begin
            res_in[i] = EW'(r_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         s_ff[i] <= s_in[i];
         s2_ff[i] <= s_ff[i];
         plo_ff[i] <= plo_in[i];
         phi_ff[i] <= phi_in[i];
         s3_ff[i] <= s2_ff[i];
         q_ff[i] <= q_in[i];
         r_ff[i] <= r_in[i];
         res_ff[i] <= res_in[i];
      end
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], start};
      end
   end

   assign result = {res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
   assign stat.done = vld_ff[4];
   assign stat.busy = |vld_ff;

endmodule
`default_nettype wire

FILE: design/mmst_back.sv
`default_nettype none
module mmst_back #(
   parameter int LEAVES = mmst_pkg::LEAVES_DEFAULT,
   localparam int LOG2P = $clog2(LEAVES),
   localparam int P = 1 << LOG2P,
   localparam int NODES = 2 * P,
   localparam int NW = LOG2P + 1,
   localparam int PW = LOG2P + 1,
   localparam int EW = PW + 1,
   localparam int LW = $clog2(LOG2P + 1),
   localparam int CW = mmst_pkg::cmd_width(LEAVES)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [CW-1:0]               cmd_data,
   input  wire mmst_pkg::fifo_stat_type     fifo_stat,
   output logic                             cmd_pop,
   output logic                             mul_start,
   output logic [mmst_pkg::MAT_W-1:0]       mul_a,
   output logic [mmst_pkg::MAT_W-1:0]       mul_b,
   input  wire logic [mmst_pkg::MAT_W-1:0]  mul_result,
   input  wire mmst_pkg::mul_stat_type      mul_stat,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [63:0]                      rsp_tdata,
   output mmst_pkg::back_stat_type          stat
);

   localparam int MW = mmst_pkg::MAT_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_L_READ,
      ST_L_WAIT,
      ST_L_MUL,
      ST_Q_WALK,
      ST_Q_WAIT,
      ST_Q_MUL,
      ST_R_WAIT,
      ST_FIN
   } state_type;

   state_type             state_ff, state_in;
   logic [NW-1:0]         clr_ff, clr_in;
   logic [NW-1:0]         k_ff, k_in;
   logic [MW-1:0]         cur_ff, cur_in;
   logic [MW-1:0]         acc_ff, acc_in;
   logic [MW-1:0]         res_ff, res_in;
   logic [NW-1:0]         v_ff, v_in;
   logic [LW-1:0]         lvl_ff, lvl_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [PW-1:0]         hi_ff, hi_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0]         rsp_data_ff, rsp_data_in;

   logic [MW-1:0]         mem [NODES];
   logic [MW-1:0]         rdata_ff;
   logic                  mem_we;
   logic [NW-1:0]         mem_waddr;
   logic [MW-1:0]         mem_wdata;
   logic [NW-1:0]         rd_addr;

   mmst_pkg::cmd_kind_type cmd_kind;
   logic [MW-1:0]         cmd_mat;
   logic [NW-1:0]         cmd_node;
   logic [PW-1:0]         cmd_lo, cmd_hi;

   logic [EW-1:0]         size, hi_e, last_one, last_two, pos_next;

   assign cmd_kind = mmst_pkg::cmd_kind_type'(cmd_data[1:0]);
   assign cmd_mat = cmd_data[2 +: MW];
   assign cmd_node = cmd_data[2 + MW +: NW];
   assign cmd_lo = cmd_data[2 + MW + NW +: PW];
   assign cmd_hi = cmd_data[2 + MW + NW + PW +: PW];

   // Query walk: from leaf pos climb while a left child's parent still ends at or
   // before hi, descend while the node runs past hi, else multiply the node in.
   assign size = EW'(1) << lvl_ff;
   assign hi_e = {1'b0, hi_ff};
   assign last_one = {1'b0, pos_ff} + size - EW'(1);
   assign last_two = {1'b0, pos_ff} + (size << 1) - EW'(1);
   assign pos_next = {1'b0, pos_ff} + size;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      k_in = k_ff;
      cur_in = cur_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      v_in = v_ff;
      lvl_in = lvl_ff;
      pos_in = pos_ff;
      hi_in = hi_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = mmst_pkg::MAT_IDENT;
      rd_addr = v_ff;
      cmd_pop = 1'b0;
      mul_start = 1'b0;
      mul_a = acc_ff;
      mul_b = rdata_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_ff == NW'(NODES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + NW'(1);
            end
         end
         ST_IDLE: begin
            if (!fifo_stat.empty) begin
               cmd_pop = 1'b1;
               case (cmd_kind)
                  mmst_pkg::CMD_LOAD: begin
                     mem_we = 1'b1;
                     mem_waddr = cmd_node;
                     mem_wdata = cmd_mat;
                     cur_in = cmd_mat;
                     k_in = cmd_node;
                     state_in = ST_L_READ;
                  end
                  mmst_pkg::CMD_RANGE: begin
                     acc_in = mmst_pkg::MAT_IDENT;
                     pos_in = cmd_lo;
                     hi_in = cmd_hi;
                     v_in = NW'(P) + cmd_lo;
                     lvl_in = '0;
                     state_in = ST_Q_WALK;
                  end
                  mmst_pkg::CMD_EMPTY: begin
                     res_in = mmst_pkg::MAT_IDENT;
                     state_in = ST_FIN;
                  end
                  mmst_pkg::CMD_ROOT: begin
                     rd_addr = NW'(1);
                     state_in = ST_R_WAIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_L_READ: begin
            rd_addr = k_ff ^ NW'(1);
            state_in = ST_L_WAIT;
         end
         ST_L_WAIT: begin
            mul_start = 1'b1;
            if (k_ff[0] == 1'b0) begin
               mul_a = cur_ff;
               mul_b = rdata_ff;
            end else begin
               mul_a = rdata_ff;
               mul_b = cur_ff;
            end
            state_in = ST_L_MUL;
         end
         ST_L_MUL: begin
            if (mul_stat.done) begin
               cur_in = mul_result;
               k_in = k_ff >> 1;
               mem_we = 1'b1;
               mem_waddr = k_ff >> 1;
               mem_wdata = mul_result;
               state_in = ((k_ff >> 1) == NW'(1)) ? ST_IDLE : ST_L_READ;
            end
         end
         ST_Q_WALK: begin
            if (last_one > hi_e) begin
               v_in = v_ff << 1;
               lvl_in = lvl_ff - LW'(1);
            end else if (!v_ff[0] && last_two <= hi_e) begin
               v_in = v_ff >> 1;
               lvl_in = lvl_ff + LW'(1);
            end else begin
               rd_addr = v_ff;
               state_in = ST_Q_WAIT;
            end
         end
         ST_Q_WAIT: begin
            mul_start = 1'b1;
            state_in = ST_Q_MUL;
         end
         ST_Q_MUL: begin
            if (mul_stat.done) begin
               acc_in = mul_result;
               if (pos_next > hi_e) begin
                  res_in = mul_result;
                  state_in = ST_FIN;
               end else begin
                  pos_in = pos_next[PW-1:0];
                  v_in = v_ff + NW'(1);
                  state_in = ST_Q_WALK;
               end
            end
         end
         ST_R_WAIT: begin
            res_in = rdata_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff <= k_in;
      cur_ff <= cur_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      v_ff <= v_in;
      lvl_ff <= lvl_in;
      pos_ff <= pos_in;
      hi_ff <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign stat.init_done = (state_ff != ST_CLEAR);

endmodule
`default_nettype wire

FILE: design/matrix_mod_segment_tree_core.sv
`default_nettype none
// Channel  Side    Handshake              Beat contents
// req      in      req_tvalid/req_tready  tuser: func; tdata: leaf, matrix, range
// rsp      out     rsp_tvalid/rsp_tready  tdata: range product matrix
// csr      config  APB, pready always 1   modulus at byte address 0
//
// A load walks the back end from leaf to root: each level is one node-memory
// read and one pass through the modular multiply pipe. A query multiplies in
// each covering node and moves one level per climb or descent; an empty range
// or the whole tree skips the multiply pipe. After reset the node memory, all
// 2*P nodes (2048 at 1024 leaves), is cleared to identity and req_tready stays
// low; a modulus write holds req_tready low while the reciprocal is recomputed.
// A four-entry command queue and the result register keep the input side moving
// while rsp stalls.
module matrix_mod_segment_tree_core #(
   parameter int LEAVES = mmst_pkg::LEAVES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // leaf_index[9:0], in_m11[25:10], in_m12[41:26], in_m21[57:42],
   // in_m22[73:58], range_left[83:74], range_right[93:84], zero fill above
   input  wire logic [95:0]                      req_tdata,
   // func[0]
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_m11[15:0], out_m12[31:16], out_m21[47:32], out_m22[63:48]
   output logic [63:0]                           rsp_tdata,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mmst_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int CW = mmst_pkg::cmd_width(LEAVES);

   logic [mmst_pkg::MOD_W-1:0]   mod_eff;
   logic [mmst_pkg::RECIP_W-1:0] recip;
   mmst_pkg::csr_stat_type       csr_stat;
   mmst_pkg::fifo_stat_type      fifo_stat;
   mmst_pkg::back_stat_type      back_stat;
   mmst_pkg::mul_stat_type       mul_stat;
   logic                         push, pop, mul_start;
   logic [CW-1:0]                push_data, head_data;
   logic [mmst_pkg::MAT_W-1:0]   mul_a, mul_b, mul_result;

   mmst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mod_eff     (mod_eff),
      .recip       (recip),
      .stat        (csr_stat)
   );

   mmst_front #(.LEAVES(LEAVES)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_stat  (fifo_stat),
      .back_stat  (back_stat),
      .csr_stat   (csr_stat),
      .push       (push),
      .push_data  (push_data)
   );

   mmst_fifo #(.LEAVES(LEAVES)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .stat      (fifo_stat)
   );

   mmst_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mat_a   (mul_a),
      .mat_b   (mul_b),
      .mod_eff (mod_eff),
      .recip   (recip),
      .result  (mul_result),
      .stat    (mul_stat)
   );

   mmst_back #(.LEAVES(LEAVES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_data   (head_data),
      .fifo_stat  (fifo_stat),
      .cmd_pop    (pop),
      .mul_start  (mul_start),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_result (mul_result),
      .mul_stat   (mul_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .stat       (back_stat)
   );

   a_push_not_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_stat.full)
      else $error("command pushed into a full queue");

   a_pop_not_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_stat.empty)
      else $error("command popped from an empty queue");

   a_mul_no_restart : assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy)
      else $error("multiply started while the pipe is busy");

   a_no_result_in_clear : assert property (@(posedge clock) disable iff (reset)
      !back_stat.init_done |-> !rsp_tvalid && !req_tready)
      else $error("traffic during the clearing pass");

endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
module tb;

   localparam int NODES = 2048;
   localparam int LEAF_BASE = 1024;

   class matrix_scoreboard;
      logic [63:0] tree [NODES];
      logic [15:0] modulus;
      logic [63:0] pending [$];
      int mismatches;

      function new();
         for (int i = 0; i < NODES; i++) tree[i] = mmst_pkg::MAT_IDENT;
         modulus = mmst_pkg::MODULUS_RESET;
         mismatches = 0;
      endfunction

      function logic [15:0] dot(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                logic [15:0] d);
         longint unsigned s;
         longint unsigned m;
         m = (modulus == 0) ? 65536 : modulus;
         s = longint'(a) * b + longint'(c) * d;
         return 16'(s % m);
      endfunction

      function logic [63:0] mat_mul(logic [63:0] x, logic [63:0] y);
         logic [15:0] r11, r12, r21, r22;
         r11 = dot(x[15:0], y[15:0], x[31:16], y[47:32]);
         r12 = dot(x[15:0], y[31:16], x[31:16], y[63:48]);
         r21 = dot(x[47:32], y[15:0], x[63:48], y[47:32]);
         r22 = dot(x[47:32], y[31:16], x[63:48], y[63:48]);
         return {r22, r21, r12, r11};
      endfunction

      function logic [63:0] span(int node, int lb, int rb, int l, int r);
         int mid;
         if (l > r) return mmst_pkg::MAT_IDENT;
         if (l == lb && r == rb) return tree[node];
         mid = (lb + rb + 1) / 2;
         return mat_mul(span(2 * node, lb, mid - 1, l, (r < mid - 1) ? r : mid - 1),
                        span(2 * node + 1, mid, rb, (l > mid) ? l : mid, r));
      endfunction

      function void note_req(logic func, logic [95:0] data);
         int k;
         if (func == 1'b0) begin
            k = LEAF_BASE + int'(data[9:0]);
            tree[k] = {data[73:58], data[57:42], data[41:26], data[25:10]};
            while (k > 1) begin
               k = k >> 1;
               tree[k] = mat_mul(tree[2 * k], tree[2 * k + 1]);
            end
         end else begin
            pending.push_back(span(1, 0, LEAF_BASE - 1, int'(data[83:74]),
                                   int'(data[93:84])));
         end
      endfunction

      function void check_rsp(logic [63:0] got);
         logic [63:0] want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
         end
         want = pending.pop_front();
         for (int f = 0; f < 4; f++) begin
            if (got[16*f +: 16] !== want[16*f +: 16]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("entry %0d: expected %h, got %h", f, want[16*f +: 16],
                           got[16*f +: 16]);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [mmst_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   matrix_scoreboard sb = new();
   int csr_errors = 0;
   bit burst = 0;

   matrix_mod_segment_tree_core uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic send_beat(logic func, logic [95:0] data);
      int gap;
      gap = burst ? 0 : $urandom_range(16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      sb.note_req(func, data);
      @(negedge clock);
   endtask

   task automatic load_leaf(logic [9:0] idx, logic [15:0] m11, logic [15:0] m12,
                            logic [15:0] m21, logic [15:0] m22);
      send_beat(1'b0, {22'd0, 20'd0, m22, m21, m12, m11, idx});
   endtask

   task automatic query(logic [9:0] l, logic [9:0] r);
      send_beat(1'b1, {2'd0, r, l, 64'd0, 10'd0});
   endtask

   // Let the pipeline empty out before touching the modulus. Up to five loads
   // can still be queued or running after the last result.
   task automatic write_modulus(logic [15:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (500) @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {mmst_pkg::REG_MODULUS, 2'b00};
      csr_pwdata <= {16'($urandom_range(65535)), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== value) begin
         csr_errors++;
         $display("modulus readback: expected %h, got %h", value, csr_prdata[15:0]);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      sb.modulus = value;
   endtask

   function automatic logic [15:0] entry_value();
      int m;
      m = (sb.modulus == 0) ? 65536 : sb.modulus;
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(65535));
         default: return 16'($urandom_range(m - 1));
      endcase
   endfunction

   task automatic random_beat();
      logic [9:0] a, b;
      bit near;
      near = ($urandom_range(1) == 1);
      a = near ? 10'($urandom_range(31)) : 10'($urandom_range(1023));
      b = near ? 10'($urandom_range(31)) : 10'($urandom_range(1023));
      case ($urandom_range(9))
         0, 1, 2, 3, 4: load_leaf(a, entry_value(), entry_value(), entry_value(),
                                  entry_value());
         5: query(0, 10'd1023);
         6: query(a, a);
         default: query((a < b) ? a : b, (a < b) ? b : a);
      endcase
      if ($urandom_range(19) == 0) query((a > b) ? a : b, (a > b) ? b : a);
   endtask

   initial begin : rsp_stall
      int stall;
      wait (!reset);
      @(negedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_rsp(rsp_tdata);
            stall = burst ? 0 : $urandom_range(16);
            if (stall > 0) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      logic [15:0] moduli [6];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extremes of the leaf range and entries, whole tree, single leaves,
      // empty and inverted ranges.
      query(0, 10'd1023);
      query(10'd7, 10'd3);
      load_leaf(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      load_leaf(10'd1023, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      load_leaf(1, 16'd2, 16'd3, 16'd5, 16'd7);
      load_leaf(2, 16'hFFFE, 16'd1, 16'h8000, 16'h7FFF);
      query(0, 0);
      query(10'd1023, 10'd1023);
      query(0, 10'd1023);
      query(0, 2);
      query(1, 2);
      query(10'd1023, 0);
      query(10'd512, 10'd1023);
      query(10'd511, 10'd512);
      load_leaf(10'd512, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0);
      query(10'd500, 10'd600);
      write_modulus(16'd1);
      query(0, 10'd1023);
      query(10'd9, 10'd8);
      load_leaf(3, 16'd4, 16'd0, 16'd9, 16'd1);
      query(0, 3);
      query(3, 3);

      moduli = '{16'd0, 16'd2, 16'd65535, 16'($urandom_range(3, 65534)), 16'd97,
                 16'($urandom_range(1, 65535))};
      foreach (moduli[p]) begin
         write_modulus(moduli[p]);
         for (int i = 0; i < 120; i++) begin
            if (i % 40 == 0) burst = ($urandom_range(3) == 0);
            random_beat();
         end
         burst = 0;
      end
      write_modulus(mmst_pkg::MODULUS_RESET);
      for (int i = 0; i < 20; i++) random_beat();

      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && csr_errors == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
